>>> src/pidsc_pkg.sv
// Shared types and constants for the PID speed controller.
package pidsc_pkg;

    // Field widths
    localparam int SPEED_W     = 24;
    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 23;
    localparam int COEFF_W     = 16;
    localparam int CMD_W       = 2;
    localparam int CH_FIELD_W  = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Internal widths
    localparam int ERR_W       = SPEED_W + 1;
    localparam int ISUM_W      = SPEED_W + 2;
    localparam int DERIV_W     = 32;
    localparam int WIDE_W      = 48;
    localparam int MCAND_W     = DERIV_W + 2;
    localparam int ACC_W       = 58;
    localparam int FRAC_SHIFT  = 16;
    localparam int OUT_Q_W     = ACC_W - FRAC_SHIFT;
    localparam int CNT_W       = 5;

    localparam logic [CNT_W-1:0] GAIN_STEPS  = CNT_W'(GAIN_W);
    localparam logic [CNT_W-1:0] COEFF_STEPS = CNT_W'(COEFF_W);

    // Parameter defaults
    localparam int CHANNELS_DEF = 4;
    localparam int DT_SHIFT_DEF = 10;
    localparam int MAX_CH       = 2 ** CH_FIELD_W;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0]        ILIMIT_RST = {LIMIT_W{1'b1}};
    localparam logic signed [SPEED_W-1:0] OUT_LO_RST = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic signed [SPEED_W-1:0] OUT_HI_RST = {1'b0, {(SPEED_W-1){1'b1}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE     = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_ENABLE     = 2'd2,
        CMD_DISABLE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KP     = 3'd0,
        CFG_KI     = 3'd1,
        CFG_KD     = 3'd2,
        CFG_FF     = 3'd3,
        CFG_ILIMIT = 3'd4,
        CFG_DCOEFF = 3'd5,
        CFG_OUT_LO = 3'd6,
        CFG_OUT_HI = 3'd7
    } cfg_sel_t;

    typedef struct packed {
        cmd_t                        command;
        logic [CH_FIELD_W-1:0]       channel;
        logic signed [SPEED_W-1:0]   speed_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0]   drive_value;
        logic                        drive_valid;
    } out_item_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]    kp_gain;
        logic signed [GAIN_W-1:0]    ki_gain;
        logic signed [GAIN_W-1:0]    kd_gain;
        logic signed [GAIN_W-1:0]    ff_gain;
        logic [LIMIT_W-1:0]          integ_limit;
        logic [COEFF_W-1:0]          derivative_filter_coeff;
        logic signed [SPEED_W-1:0]   output_low_bound;
        logic signed [SPEED_W-1:0]   output_high_bound;
    } cfg_t;

    // Serial MAC control and status
    typedef struct packed {
        logic                        start;
        logic                        keep;
        logic                        sub_msb;
        logic [CNT_W-1:0]            nbits;
    } mac_ctl_t;

    typedef struct packed {
        logic                        busy;
        logic                        last;
    } mac_stat_t;

endpackage

>>> src/pidsc_cfg.sv
// Configuration register file of the PID speed controller.
module pidsc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [pidsc_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]    wr_data,
    output pidsc_pkg::cfg_t                     cfg
);

    pidsc_pkg::cfg_t cfg_reg;
    pidsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                pidsc_pkg::CFG_KP:     cfg_next.kp_gain = wr_data;
                pidsc_pkg::CFG_KI:     cfg_next.ki_gain = wr_data;
                pidsc_pkg::CFG_KD:     cfg_next.kd_gain = wr_data;
                pidsc_pkg::CFG_FF:     cfg_next.ff_gain = wr_data;
                pidsc_pkg::CFG_ILIMIT:
                    cfg_next.integ_limit = wr_data[pidsc_pkg::LIMIT_W-1:0];
                pidsc_pkg::CFG_DCOEFF:
                    cfg_next.derivative_filter_coeff = wr_data[pidsc_pkg::COEFF_W-1:0];
                pidsc_pkg::CFG_OUT_LO: cfg_next.output_low_bound = wr_data;
                pidsc_pkg::CFG_OUT_HI: cfg_next.output_high_bound = wr_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                         <= '0;
            cfg_reg.integ_limit             <= pidsc_pkg::ILIMIT_RST;
            cfg_reg.output_low_bound        <= pidsc_pkg::OUT_LO_RST;
            cfg_reg.output_high_bound       <= pidsc_pkg::OUT_HI_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/pidsc_mac.sv
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
module pidsc_mac (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pidsc_pkg::mac_ctl_t                     ctl,
    input  logic signed [pidsc_pkg::MCAND_W-1:0]    mcand,
    input  logic [pidsc_pkg::GAIN_W-1:0]            mult,
    input  logic signed [pidsc_pkg::ACC_W-1:0]      init,
    output pidsc_pkg::mac_stat_t                    stat,
    output logic signed [pidsc_pkg::ACC_W-1:0]      acc
);

    logic signed [pidsc_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [pidsc_pkg::ACC_W-1:0]  mcand_reg, mcand_next;
    logic [pidsc_pkg::GAIN_W-1:0]        mult_reg, mult_next;
    logic [pidsc_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                                busy_reg, busy_next;
    logic                                sub_reg, sub_next;
    logic                                last;
    logic signed [pidsc_pkg::ACC_W-1:0]  addend;

    assign last   = busy_reg && (cnt_reg == '0);
    assign addend = mult_reg[0] ? mcand_reg : '0;

    always_comb
    begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        sub_next   = sub_reg;
        if (ctl.start)
        begin
            acc_next   = ctl.keep ? acc_reg : init;
            mcand_next = pidsc_pkg::ACC_W'(mcand);
            mult_next  = mult;
            cnt_next   = ctl.nbits - 1'b1;
            busy_next  = 1'b1;
            sub_next   = ctl.sub_msb;
        end
        else if (busy_reg)
        begin
            // the sign bit of a two's complement multiplier weighs negative
            acc_next   = (last && sub_reg) ? acc_reg - addend : acc_reg + addend;
            mcand_next = mcand_reg <<< 1;
            mult_next  = mult_reg >> 1;
            cnt_next   = cnt_reg - 1'b1;
            busy_next  = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        sub_reg   <= sub_next;
    end

    assign stat.busy = busy_reg;
    assign stat.last = last;
    assign acc       = acc_reg;

endmodule

>>> src/pid_speed_controller.sv
// Top level of the multi-channel PID speed controller.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-----------------------------
//   in       | input     | in_valid / in_stall | in_data   (command, channel,
//            |           |                     |            speed_value)
//   out      | output    | out_valid/out_stall | out_data  (drive_value,
//            |           |                     |            drive_valid)
//   cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An update on an enabled channel runs the serial MAC for four 24-step gain
// products, plus one 16-step filter product when the derivative filter is on.
// Any other item goes straight to the output. One item is worked on at a time.
// rst_n clears all channel history, disables all loops and loads the
// register defaults. A stalled output holds its result while the next item
// is taken in; the block waits before its own result only if that is still held.
module pid_speed_controller #(
    parameter int CHANNELS = pidsc_pkg::CHANNELS_DEF,
    parameter int DT_SHIFT = pidsc_pkg::DT_SHIFT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pidsc_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pidsc_pkg::out_item_t                out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Only channel codes below CHANNELS that the field can carry get storage.
    localparam int NUM_CH = (CHANNELS < pidsc_pkg::MAX_CH) ? CHANNELS : pidsc_pkg::MAX_CH;
    localparam int IDX_W  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

    localparam int SPEED_W = pidsc_pkg::SPEED_W;
    localparam int ERR_W   = pidsc_pkg::ERR_W;
    localparam int ISUM_W  = pidsc_pkg::ISUM_W;
    localparam int DERIV_W = pidsc_pkg::DERIV_W;
    localparam int WIDE_W  = pidsc_pkg::WIDE_W;
    localparam int MCAND_W = pidsc_pkg::MCAND_W;
    localparam int ACC_W   = pidsc_pkg::ACC_W;
    localparam int FRAC    = pidsc_pkg::FRAC_SHIFT;
    localparam int OUT_Q_W = pidsc_pkg::OUT_Q_W;

    localparam logic signed [WIDE_W-1:0] RAW_MAX =
        {{(WIDE_W-DERIV_W+1){1'b0}}, {(DERIV_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] RAW_MIN =
        {{(WIDE_W-DERIV_W+1){1'b1}}, {(DERIV_W-1){1'b0}}};

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_ERR   = 10'b0000000010,
        ST_TERMS = 10'b0000000100,
        ST_FLOAD = 10'b0000001000,
        ST_FILT  = 10'b0000010000,
        ST_DERIV = 10'b0000100000,
        ST_NEXT  = 10'b0001000000,
        ST_MAC   = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_PUSH  = 10'b1000000000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    pidsc_pkg::cfg_t cfg_q;

    assign cfg_ready = 1'b1;

    pidsc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg_q)
    );

    // ------------------------------------------------------------------
    // Control and per-item work registers
    // ------------------------------------------------------------------
    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             ch_reg, ch_next;
    logic signed [SPEED_W-1:0]    speed_reg, speed_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic signed [SPEED_W-1:0]    inew_reg, inew_next;
    logic signed [DERIV_W-1:0]    raw_reg, raw_next;
    logic signed [DERIV_W-1:0]    deriv_reg, deriv_next;
    logic [1:0]                   term_reg, term_next;
    pidsc_pkg::out_item_t         result_reg, result_next;
    logic                         out_valid_reg, out_valid_next;
    pidsc_pkg::out_item_t         out_data_reg, out_data_next;

    // Per-channel history
    logic signed [SPEED_W-1:0]    target_reg [NUM_CH];
    logic signed [SPEED_W-1:0]    target_next [NUM_CH];
    logic signed [SPEED_W-1:0]    integ_reg [NUM_CH];
    logic signed [SPEED_W-1:0]    integ_next [NUM_CH];
    logic signed [ERR_W-1:0]      perr_reg [NUM_CH];
    logic signed [ERR_W-1:0]      perr_next [NUM_CH];
    logic signed [DERIV_W-1:0]    pderiv_reg [NUM_CH];
    logic signed [DERIV_W-1:0]    pderiv_next [NUM_CH];
    logic [NUM_CH-1:0]            enabled_reg, enabled_next;

    // ------------------------------------------------------------------
    // Serial MAC
    // ------------------------------------------------------------------
    pidsc_pkg::mac_ctl_t              mac_ctl;
    pidsc_pkg::mac_stat_t             mac_stat;
    logic signed [MCAND_W-1:0]        mac_mcand;
    logic [pidsc_pkg::GAIN_W-1:0]     mac_mult;
    logic signed [ACC_W-1:0]          mac_init;
    logic signed [ACC_W-1:0]          mac_acc;

    pidsc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .mcand (mac_mcand),
        .mult  (mac_mult),
        .init  (mac_init),
        .stat  (mac_stat),
        .acc   (mac_acc)
    );

    // ------------------------------------------------------------------
    // Datapath of one update
    // ------------------------------------------------------------------
    logic                         ch_ok;
    logic [IDX_W-1:0]             in_idx;
    logic signed [SPEED_W-1:0]    cur_target;
    logic signed [SPEED_W-1:0]    cur_integ;
    logic signed [ERR_W-1:0]      cur_perr;
    logic signed [DERIV_W-1:0]    cur_pderiv;
    logic signed [ERR_W-1:0]      inc;
    logic signed [ISUM_W-1:0]     isum;
    logic signed [ISUM_W-1:0]     ilim;
    logic signed [SPEED_W-1:0]    integ_clamped;
    logic signed [ISUM_W-1:0]     err_delta;
    logic signed [WIDE_W-1:0]     raw_wide;
    logic signed [DERIV_W-1:0]    raw_sat;
    logic signed [MCAND_W-1:0]    filt_mcand;
    logic signed [ACC_W-1:0]      filt_init;
    logic signed [MCAND_W-1:0]    term_mcand;
    logic [pidsc_pkg::GAIN_W-1:0] term_mult;
    logic signed [OUT_Q_W-1:0]    sum_q;
    logic signed [OUT_Q_W-1:0]    hi_q;
    logic signed [OUT_Q_W-1:0]    lo_q;
    logic signed [SPEED_W-1:0]    drive;
    logic                         out_load;

    assign ch_ok  = (32'(in_data.channel) < NUM_CH);
    assign in_idx = in_data.channel[IDX_W-1:0];

    assign cur_target = target_reg[ch_reg];
    assign cur_integ  = integ_reg[ch_reg];
    assign cur_perr   = perr_reg[ch_reg];
    assign cur_pderiv = pderiv_reg[ch_reg];

    // integral: add the error scaled by the time step, clamp to the limit
    assign inc  = err_reg >>> DT_SHIFT;
    assign isum = ISUM_W'(cur_integ) + ISUM_W'(inc);
    assign ilim = ISUM_W'($signed({1'b0, cfg_q.integ_limit}));

    always_comb
    begin
        if (isum > ilim)
            integ_clamped = ilim[SPEED_W-1:0];
        else if (isum < -ilim)
            integ_clamped = -ilim[SPEED_W-1:0];
        else
            integ_clamped = isum[SPEED_W-1:0];
    end

    // raw derivative: error step over the time step, saturate to 32 bits
    assign err_delta = ISUM_W'(err_reg) - ISUM_W'(cur_perr);
    assign raw_wide  = WIDE_W'(err_delta) <<< DT_SHIFT;

    always_comb
    begin
        if (raw_wide > RAW_MAX)
            raw_sat = RAW_MAX[DERIV_W-1:0];
        else if (raw_wide < RAW_MIN)
            raw_sat = RAW_MIN[DERIV_W-1:0];
        else
            raw_sat = raw_wide[DERIV_W-1:0];
    end

    // filter as c*(raw - prev) + prev*2^16
    assign filt_mcand = MCAND_W'(raw_reg) - MCAND_W'(cur_pderiv);
    assign filt_init  = {{(ACC_W-DERIV_W-FRAC){cur_pderiv[DERIV_W-1]}},
                         cur_pderiv, {FRAC{1'b0}}};

    always_comb
    begin
        case (term_reg)
            2'd0:
            begin
                term_mcand = MCAND_W'(err_reg);
                term_mult  = cfg_q.kp_gain;
            end
            2'd1:
            begin
                term_mcand = MCAND_W'(inew_reg);
                term_mult  = cfg_q.ki_gain;
            end
            2'd2:
            begin
                term_mcand = MCAND_W'(deriv_reg);
                term_mult  = cfg_q.kd_gain;
            end
            default:
            begin
                term_mcand = MCAND_W'(cur_target);
                term_mult  = cfg_q.ff_gain;
            end
        endcase
    end

    // output: drop the gain fraction, then clamp (high bound wins if crossed)
    assign sum_q = $signed(mac_acc[ACC_W-1:FRAC]);
    assign hi_q  = OUT_Q_W'(cfg_q.output_high_bound);
    assign lo_q  = OUT_Q_W'(cfg_q.output_low_bound);

    always_comb
    begin
        if (sum_q > hi_q)
            drive = cfg_q.output_high_bound;
        else if (sum_q < lo_q)
            drive = cfg_q.output_low_bound;
        else
            drive = sum_q[SPEED_W-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        speed_next   = speed_reg;
        err_next     = err_reg;
        inew_next    = inew_reg;
        raw_next     = raw_reg;
        deriv_next   = deriv_reg;
        term_next    = term_reg;
        result_next  = result_reg;
        target_next  = target_reg;
        integ_next   = integ_reg;
        perr_next    = perr_reg;
        pderiv_next  = pderiv_reg;
        enabled_next = enabled_reg;
        mac_ctl      = '0;
        mac_mcand    = '0;
        mac_mult     = '0;
        mac_init     = '0;
        out_load     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next     = in_idx;
                    speed_next  = in_data.speed_value;
                    result_next = '0;
                    state_next  = ST_PUSH;
                    if (ch_ok)
                    begin
                        case (in_data.command)
                            pidsc_pkg::CMD_UPDATE:
                            begin
                                if (enabled_reg[in_idx])
                                    state_next = ST_ERR;
                            end
                            pidsc_pkg::CMD_SET_TARGET:
                                target_next[in_idx] = in_data.speed_value;
                            pidsc_pkg::CMD_ENABLE:
                            begin
                                enabled_next[in_idx] = 1'b1;
                                integ_next[in_idx]   = '0;
                                perr_next[in_idx]    = '0;
                                pderiv_next[in_idx]  = '0;
                            end
                            pidsc_pkg::CMD_DISABLE:
                                enabled_next[in_idx] = 1'b0;
                            default:
                                state_next = ST_PUSH;
                        endcase
                    end
                end
            end

            ST_ERR:
            begin
                err_next   = ERR_W'(cur_target) - ERR_W'(speed_reg);
                state_next = ST_TERMS;
            end

            ST_TERMS:
            begin
                inew_next = integ_clamped;
                raw_next  = raw_sat;
                term_next = '0;
                if (cfg_q.derivative_filter_coeff != '0)
                begin
                    state_next = ST_FLOAD;
                end
                else
                begin
                    deriv_next = raw_sat;
                    state_next = ST_NEXT;
                end
            end

            ST_FLOAD:
            begin
                mac_ctl.start   = 1'b1;
                mac_ctl.nbits   = pidsc_pkg::COEFF_STEPS;
                mac_mcand       = filt_mcand;
                mac_mult        = pidsc_pkg::GAIN_W'(cfg_q.derivative_filter_coeff);
                mac_init        = filt_init;
                state_next      = ST_FILT;
            end

            ST_FILT:
            begin
                if (mac_stat.last)
                    state_next = ST_DERIV;
            end

            ST_DERIV:
            begin
                deriv_next = mac_acc[FRAC +: DERIV_W];
                state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                mac_ctl.start   = 1'b1;
                mac_ctl.keep    = (term_reg != 2'd0);
                mac_ctl.sub_msb = 1'b1;
                mac_ctl.nbits   = pidsc_pkg::GAIN_STEPS;
                mac_mcand       = term_mcand;
                mac_mult        = term_mult;
                state_next      = ST_MAC;
            end

            ST_MAC:
            begin
                if (mac_stat.last)
                begin
                    if (term_reg == 2'd3)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        term_next  = term_reg + 1'b1;
                        state_next = ST_NEXT;
                    end
                end
            end

            ST_OUT:
            begin
                result_next.drive_value = drive;
                result_next.drive_valid = 1'b1;
                integ_next[ch_reg]      = inew_reg;
                perr_next[ch_reg]       = err_reg;
                pderiv_next[ch_reg]     = deriv_reg;
                state_next              = ST_PUSH;
            end

            ST_PUSH:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            term_reg      <= '0;
            enabled_reg   <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                target_reg[i] <= '0;
                integ_reg[i]  <= '0;
                perr_reg[i]   <= '0;
                pderiv_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            term_reg      <= term_next;
            enabled_reg   <= enabled_next;
            target_reg    <= target_next;
            integ_reg     <= integ_next;
            perr_reg      <= perr_next;
            pderiv_reg    <= pderiv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        speed_reg    <= speed_next;
        err_reg      <= err_next;
        inew_reg     <= inew_next;
        raw_reg      <= raw_next;
        deriv_reg    <= deriv_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mac_stat.busy)
        else $error("serial MAC still busy while waiting for a transfer");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.drive_valid |-> out_data.drive_value == '0)
        else $error("result without a run carries a nonzero drive");

    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.drive_valid |->
            (out_data.drive_value <= cfg_q.output_high_bound) ||
            (out_data.drive_value == cfg_q.output_low_bound))
        else $error("drive outside the output bounds");

endmodule

>>> bench/tb_pid_speed_controller.sv
// Self-checking testbench for the multi-channel PID speed controller.
module tb_pid_speed_controller;

    import pidsc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 130;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 240;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 24'h7FFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 24'h800000;
    localparam logic [SPEED_W-1:0] GAIN_ONE  = 24'h010000;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Block ports; every input starts from a known value
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    pid_speed_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the register file and of the per-channel loop state
    cfg_t   gains;
    longint chan_target     [CHANNELS_DEF];
    longint chan_integral   [CHANNELS_DEF];
    longint chan_prev_err   [CHANNELS_DEF];
    longint chan_prev_deriv [CHANNELS_DEF];
    bit     chan_enabled    [CHANNELS_DEF];

    // Drive results still owed by the block, oldest first
    out_item_t drive_expected[$];

    // Run statistics
    int error_count    = 0;
    int items_sent     = 0;
    int updates_sent   = 0;
    int results_seen   = 0;
    int settings_count = 0;

    // Idle behavior: 0 = none, 1 = light, 2 = heavy
    int in_gap_mode = 0;
    int stall_mode  = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Bring the shadow state to its post-reset values.
    function automatic void reset_model();
        gains.kp_gain                 = '0;
        gains.ki_gain                 = '0;
        gains.kd_gain                 = '0;
        gains.ff_gain                 = '0;
        gains.integ_limit             = ILIMIT_RST;
        gains.derivative_filter_coeff = '0;
        gains.output_low_bound        = OUT_LO_RST;
        gains.output_high_bound       = OUT_HI_RST;
        for (int ch = 0; ch < CHANNELS_DEF; ch++)
        begin
            chan_target[ch]     = 0;
            chan_integral[ch]   = 0;
            chan_prev_err[ch]   = 0;
            chan_prev_deriv[ch] = 0;
            chan_enabled[ch]    = 1'b0;
        end
    endfunction

    // Apply one command to the shadow loop state and return the drive it yields.
    function automatic out_item_t pid_drive(input in_item_t item);
        out_item_t res;
        int        ch;
        longint    meas, err, integ, raw, deriv, sum, drive;
        longint    kp, ki, kd, ff, lim, coeff, lo, hi;
        res   = '0;
        ch    = item.channel;
        meas  = item.speed_value;
        kp    = gains.kp_gain;
        ki    = gains.ki_gain;
        kd    = gains.kd_gain;
        ff    = gains.ff_gain;
        lim   = gains.integ_limit;
        coeff = gains.derivative_filter_coeff;
        lo    = gains.output_low_bound;
        hi    = gains.output_high_bound;
        if (ch >= CHANNELS_DEF)
            return res;
        case (item.command)
            CMD_SET_TARGET:
                chan_target[ch] = meas;
            CMD_ENABLE:
            begin
                chan_enabled[ch]    = 1'b1;
                chan_integral[ch]   = 0;
                chan_prev_err[ch]   = 0;
                chan_prev_deriv[ch] = 0;
            end
            CMD_DISABLE:
                chan_enabled[ch] = 1'b0;
            default:
            begin
                if (chan_enabled[ch])
                begin
                    err   = chan_target[ch] - meas;
                    integ = chan_integral[ch] + (err >>> DT_SHIFT_DEF);
                    if (integ > lim)
                        integ = lim;
                    else if (integ < -lim)
                        integ = -lim;
                    raw = (err - chan_prev_err[ch]) * (longint'(1) << DT_SHIFT_DEF);
                    if (raw > 64'sd2147483647)
                        raw = 64'sd2147483647;
                    else if (raw < -64'sd2147483648)
                        raw = -64'sd2147483648;
                    if (coeff != 0)
                        deriv = (coeff * raw + (65536 - coeff) * chan_prev_deriv[ch]) >>> 16;
                    else
                        deriv = raw;
                    sum   = kp * err + ki * integ + kd * deriv + ff * chan_target[ch];
                    drive = sum >>> FRAC_SHIFT;
                    if (drive > hi)
                        drive = hi;
                    else if (drive < lo)
                        drive = lo;
                    chan_integral[ch]   = integ;
                    chan_prev_err[ch]   = err;
                    chan_prev_deriv[ch] = deriv;
                    res.drive_value     = drive[SPEED_W-1:0];
                    res.drive_valid     = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random value sources
    // ------------------------------------------------------------------

    // Idle length: mostly short, now and then long.
    function automatic int draw_gap(input int mode);
        int unsigned roll;
        roll = $urandom_range(99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (roll < 70)
                return 0;
            if (roll < 96)
                return $urandom_range(3, 1);
            return $urandom_range(60, 10);
        end
        if (roll < 35)
            return 0;
        if (roll < 88)
            return $urandom_range(8, 1);
        return $urandom_range(150, 20);
    endfunction

    function automatic logic [SPEED_W-1:0] edge_value();
        case ($urandom_range(4))
            0:       return SPEED_MIN;
            1:       return SPEED_MAX;
            2:       return 24'h000000;
            3:       return 24'h000001;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] span_value(input int span);
        return 24'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [SPEED_W-1:0] random_speed();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return edge_value();
        if (roll < 55)
            return span_value(16384);
        return 24'($urandom);
    endfunction

    // Mostly closed-loop updates, with a sprinkling of target changes,
    // re-enables and disables that break the sequence.
    function automatic in_item_t random_item();
        in_item_t    item;
        int unsigned roll;
        roll             = $urandom_range(99);
        item.channel     = 2'($urandom_range(3));
        item.speed_value = random_speed();
        if (roll < 70)
            item.command = CMD_UPDATE;
        else if (roll < 84)
            item.command = CMD_SET_TARGET;
        else if (roll < 93)
            item.command = CMD_ENABLE;
        else
            item.command = CMD_DISABLE;
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        $display("%0t MISMATCH: %0s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------

    // Hand one command to the block; predict its drive at the transfer.
    // in_valid stays high on return so back-to-back commands need no
    // second assignment in the same step.
    task automatic send_item(input in_item_t item);
        int gap;
        gap = draw_gap(in_gap_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        drive_expected.push_back(pid_drive(item));
        items_sent++;
        if (item.command == CMD_UPDATE)
            updates_sent++;
        @(negedge clk);
    endtask

    task automatic send_cmd(input cmd_t cmd, input int ch, input logic [SPEED_W-1:0] speed);
        in_item_t item;
        item.command     = cmd;
        item.channel     = 2'(ch);
        item.speed_value = speed;
        send_item(item);
    endtask

    // Write one register; cfg_valid is left high for the caller to drop.
    task automatic write_reg(input cfg_sel_t sel, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= sel;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            CFG_KP:     gains.kp_gain                 = data;
            CFG_KI:     gains.ki_gain                 = data;
            CFG_KD:     gains.kd_gain                 = data;
            CFG_FF:     gains.ff_gain                 = data;
            CFG_ILIMIT: gains.integ_limit             = data[LIMIT_W-1:0];
            CFG_DCOEFF: gains.derivative_filter_coeff = data[COEFF_W-1:0];
            CFG_OUT_LO: gains.output_low_bound        = data;
            default:    gains.output_high_bound       = data;
        endcase
        @(negedge clk);
    endtask

    // Load the whole register file; only call while the block is idle.
    task automatic set_regs(input logic [23:0] kp, input logic [23:0] ki,
                            input logic [23:0] kd, input logic [23:0] ff,
                            input logic [23:0] lim, input logic [23:0] coeff,
                            input logic [23:0] lo, input logic [23:0] hi);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_FF, ff);
        write_reg(CFG_ILIMIT, lim);
        write_reg(CFG_DCOEFF, coeff);
        write_reg(CFG_OUT_LO, lo);
        write_reg(CFG_OUT_HI, hi);
        cfg_valid <= 1'b0;
        settings_count++;
        @(negedge clk);
    endtask

    // Drop in_valid, let every owed result arrive, then pause briefly.
    task automatic drain();
        in_valid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and the result check
    // ------------------------------------------------------------------

    // Alternate open and stalled runs; with stall_mode at zero, hold open.
    int stall_run = 0;

    always @(negedge clk)
    begin
        if (stall_run > 0)
            stall_run = stall_run - 1;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_run = draw_gap(stall_mode) + $urandom_range(12);
        end
        else if (stall_mode != 0)
        begin
            out_stall <= 1'b1;
            stall_run = draw_gap(stall_mode);
        end
    end

    // Compare every drive transfer with the oldest prediction.
    always @(posedge clk)
    begin : check_drive
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (drive_expected.size() == 0)
                flag_mismatch($sformatf("drive result %0d arrived with nothing owed",
                                        results_seen));
            else
            begin
                want = drive_expected.pop_front();
                if (out_data.drive_value !== want.drive_value)
                    flag_mismatch($sformatf("result %0d drive_value got %h want %h",
                                            results_seen, out_data.drive_value,
                                            want.drive_value));
                if (out_data.drive_valid !== want.drive_valid)
                    flag_mismatch($sformatf("result %0d drive_valid got %b want %b",
                                            results_seen, out_data.drive_valid,
                                            want.drive_valid));
            end
        end
    end

    // Watchdog: end the run if no transfer happens on any channel for too long.
    int quiet_cycles = 0;

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no transfer for %0d cycles, %0d results owed",
                 WATCHDOG_LIMIT, drive_expected.size());
        $display("tb_pid_speed_controller: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: all gains zero, so an enabled update drives zero.
    // Also cover an update and a disable on a loop that was never enabled.
    task automatic test_reset_state();
        send_cmd(CMD_UPDATE, 0, SPEED_MAX);
        send_cmd(CMD_SET_TARGET, 0, SPEED_MAX);
        send_cmd(CMD_ENABLE, 0, 24'h000000);
        send_cmd(CMD_UPDATE, 0, SPEED_MIN);
        send_cmd(CMD_DISABLE, 3, 24'hFFFFFF);
        send_cmd(CMD_UPDATE, 3, 24'h000001);
    endtask

    // Gains at both extremes, integral limit at both ends, filter fully open,
    // and a second enable on a loop that is already running.
    task automatic test_gain_extremes();
        drain();
        set_regs(SPEED_MAX, SPEED_MAX, SPEED_MAX, SPEED_MAX,
                 24'h7FFFFF, 24'h000000, SPEED_MIN, SPEED_MAX);
        send_cmd(CMD_UPDATE, 0, SPEED_MAX);
        send_cmd(CMD_UPDATE, 0, SPEED_MIN);
        send_cmd(CMD_ENABLE, 0, SPEED_MAX);
        send_cmd(CMD_UPDATE, 0, 24'h000000);
        send_cmd(CMD_SET_TARGET, 1, SPEED_MIN);
        send_cmd(CMD_ENABLE, 1, SPEED_MIN);
        send_cmd(CMD_UPDATE, 1, SPEED_MAX);
        drain();
        set_regs(SPEED_MIN, SPEED_MIN, SPEED_MIN, SPEED_MIN,
                 24'h000000, 24'h00FFFF, SPEED_MIN, SPEED_MAX);
        send_cmd(CMD_ENABLE, 2, 24'h000000);
        send_cmd(CMD_UPDATE, 2, SPEED_MAX);
        send_cmd(CMD_UPDATE, 2, SPEED_MIN);
        send_cmd(CMD_UPDATE, 2, 24'hFFFFFF);
    endtask

    // Low bound above high bound: a sum over the high bound gives the high
    // bound, anything else under the low bound gives the low bound. Use the
    // smallest filter weight and an integral limit of one step.
    task automatic test_crossed_bounds();
        drain();
        set_regs(GAIN_ONE, 24'h000000, 24'h000000, 24'h000000,
                 24'h000001, 24'h000001, 24'h000400, 24'hFFFC00);
        send_cmd(CMD_SET_TARGET, 3, 24'h000000);
        send_cmd(CMD_ENABLE, 3, 24'h000000);
        send_cmd(CMD_UPDATE, 3, 24'hF00000);
        send_cmd(CMD_UPDATE, 3, 24'h100000);
        send_cmd(CMD_UPDATE, 3, 24'h000000);
        send_cmd(CMD_DISABLE, 0, 24'h000000);
        send_cmd(CMD_UPDATE, 0, 24'h000100);
    endtask

    // Random phases: each loads a fresh register setting, opens every loop
    // with a target and an enable, then streams mostly updates.
    task automatic test_random_traffic();
        logic [23:0] r [8];
        int          style;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            style = phase % 3;
            case (style)
                0:
                begin
                    // Moderate gains so outputs mostly land inside the bounds
                    r[0] = span_value(1 << 18);
                    r[1] = span_value(1 << 16);
                    r[2] = span_value(1 << 12);
                    r[3] = span_value(1 << 17);
                    r[4] = 24'($urandom_range(1 << 20));
                    r[5] = ($urandom_range(9) < 3) ? 24'h0 : 24'($urandom_range(65535));
                    r[6] = 24'(-int'($urandom_range(1 << 22)));
                    r[7] = 24'($urandom_range(1 << 22));
                end
                1:
                begin
                    for (int k = 0; k < 8; k++)
                        r[k] = 24'($urandom);
                end
                default:
                begin
                    for (int k = 0; k < 8; k++)
                        r[k] = edge_value();
                    r[4] = ($urandom_range(1) == 0) ? 24'h000000 : 24'h7FFFFF;
                    r[5] = ($urandom_range(1) == 0) ? 24'h000000 : 24'h00FFFF;
                end
            endcase
            set_regs(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7]);
            // Keep the first phase free of idling on both sides
            in_gap_mode = (phase == 0) ? 0 : $urandom_range(2, 1);
            stall_mode  = (phase == 0) ? 0 : $urandom_range(2, 1);
            for (int ch = 0; ch < CHANNELS_DEF; ch++)
            begin
                send_cmd(CMD_SET_TARGET, ch, random_speed());
                send_cmd(CMD_ENABLE, ch, random_speed());
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_item());
        end
    endtask

    // Wait out the last results plus the block's longest update, then report.
    task automatic finish_run();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (drive_expected.size() != 0)
            flag_mismatch($sformatf("%0d drive results never arrived",
                                    drive_expected.size()));
        $display("Sent %0d commands (%0d updates) under %0d register settings",
                 items_sent, updates_sent, settings_count);
        $display("Checked %0d drive results, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("tb_pid_speed_controller: clean");
        else
            $display("tb_pid_speed_controller: errors");
        $finish;
    endtask

    // Hold reset, then release it and run each test in turn.
    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_state();
        test_gain_extremes();
        test_crossed_bounds();
        test_random_traffic();
        finish_run();
    end

endmodule

>>> filelist.f
src/pidsc_pkg.sv
src/pidsc_cfg.sv
src/pidsc_mac.sv
src/pid_speed_controller.sv
bench/tb_pid_speed_controller.sv
